>>> design/dsp_pkg.sv
// shared types, register codes and constants for the diffuse sphere profile block
package dsp_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CENTRE_X      = 3'd0;
  localparam logic [2:0] REG_CENTRE_Y      = 3'd1;
  localparam logic [2:0] REG_CENTRE_Z      = 3'd2;
  localparam logic [2:0] REG_RADIUS        = 3'd3;
  localparam logic [2:0] REG_WIDTH         = 3'd4;
  localparam logic [2:0] REG_INSIDE_VALUE  = 3'd5;
  localparam logic [2:0] REG_OUTSIDE_VALUE = 3'd6;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;
  localparam logic [23:0] WIDTH_RESET = 24'd256;

  // exp(-1) in q.32 from the truncated series
  localparam logic [32:0] E1_Q32 = 33'd1580030169;

  // start beat to result strobe, in clock edges
  localparam int DSP_LATENCY = 132;

  typedef struct packed {
    logic        valid;
    logic [24:0] distance;
  } dist_beat_t;

  typedef struct packed {
    logic        valid;
    logic        sat;
    logic        neg;
    logic [18:0] amag;
  } arg_beat_t;

  typedef struct packed {
    logic        valid;
    logic [29:0] weight;
  } weight_beat_t;

  // exp(-1)^n in q.32, truncated after every product
  function automatic logic [15:0][32:0] e1_pow_table();
    logic [15:0][32:0] tab;
    logic [65:0]       prod;
    tab[0] = ONE_Q32;
    for (int i = 1; i < 16; i++) begin
      prod   = 66'(tab[i-1]) * 66'(E1_Q32);
      tab[i] = 33'(prod >> 32);
    end
    return tab;
  endfunction

  localparam logic [15:0][32:0] E1_POW = e1_pow_table();

endpackage

>>> design/diffuse_sphere_profile_top.sv
// top level of the diffuse sphere profile block: registers, pipeline and blend
//
// blends inside_value and outside_value across a tanh interface around a sphere
// input channel: point_x/y/z are taken at a clock edge with start high and busy
//   low; busy stays low, so one point can start on every cycle
// result channel: result_valid strobes for one cycle with field_value; the
//   receiver has no way to hold it off and none is needed
// configuration: cfg_valid with cfg_index and cfg_data writes one register;
//   cfg_ready is always high, indexes past outside_value are dropped;
//   registers must change only while no point is in flight, which the user
//   ensures; the block itself does not enforce it
// pipeline: distance and square root (one root bit per stage), argument
//   division (one quotient bit per stage), tanh (three stages per series
//   term, power and scale, 29 divider stages, weight), then blend
// throughput: one point per cycle, every stage is a register with a valid bit
// reset: synchronous; clears every valid bit and loads the register defaults
//   (centre 0, radius 0, width 256, values 0); beats in flight are dropped
module diffuse_sphere_profile_top import dsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  output logic               result_valid,
  output logic signed [31:0] field_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [23:0] centre_x, centre_y, centre_z;
  logic [23:0]        radius, width;
  logic signed [31:0] inside_value, outside_value;

  // the pipeline never stalls, so no beat is ever refused
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x      <= '0;
      centre_y      <= '0;
      centre_z      <= '0;
      radius        <= '0;
      width         <= WIDTH_RESET;
      inside_value  <= '0;
      outside_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTRE_X:      centre_x      <= signed'(cfg_data[23:0]);
        REG_CENTRE_Y:      centre_y      <= signed'(cfg_data[23:0]);
        REG_CENTRE_Z:      centre_z      <= signed'(cfg_data[23:0]);
        REG_RADIUS:        radius        <= cfg_data[23:0];
        REG_WIDTH:         width         <= cfg_data[23:0];
        REG_INSIDE_VALUE:  inside_value  <= signed'(cfg_data);
        REG_OUTSIDE_VALUE: outside_value <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  dist_beat_t   dist_beat;
  arg_beat_t    arg_beat;
  weight_beat_t wt_beat;

  dsp_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .centre_x (centre_x),
    .centre_y (centre_y),
    .centre_z (centre_z),
    .dout     (dist_beat)
  );

  dsp_arg u_arg (
    .clk    (clk),
    .rst    (rst),
    .din    (dist_beat),
    .radius (radius),
    .width  (width),
    .dout   (arg_beat)
  );

  dsp_tanh u_tanh (
    .clk  (clk),
    .rst  (rst),
    .din  (arg_beat),
    .dout (wt_beat)
  );

  // value span, recomputed every cycle from the registers
  logic signed [32:0] diff;
  logic [32:0]        dmag;
  logic               dpos;

  assign diff = 33'(outside_value) - 33'(inside_value);

  always_ff @(posedge clk) begin
    dmag <= diff[32] ? 33'(-diff) : 33'(diff);
    dpos <= !diff[32];
  end

  // blend: span times weight, rounded half up, applied toward outside_value
  logic        bv;
  logic [62:0] prod;
  logic [33:0] qv;

  assign qv = 34'((prod + 63'(ONE_Q28)) >> 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      bv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      bv           <= wt_beat.valid;
      result_valid <= bv;
    end
    prod        <= 63'(dmag) * 63'(wt_beat.weight);
    field_value <= dpos ? inside_value + signed'(qv[31:0])
                        : inside_value - signed'(qv[31:0]);
  end

endmodule

>>> design/dsp_dist.sv
// distance stages: axis differences, squares, sum and a pipelined integer square root
module dsp_dist import dsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  input  logic signed [23:0] centre_x,
  input  logic signed [23:0] centre_y,
  input  logic signed [23:0] centre_z,
  output dist_beat_t         dout
);

  logic signed [24:0] dx, dy, dz;
  logic v1, v2;
  logic [24:0] mx, my, mz;
  logic [48:0] sqx, sqy, sqz;

  logic        vld [0:25];
  logic [49:0] rem [0:25];
  logic [49:0] root [0:25];

  assign dx = 25'(point_x) - 25'(centre_x);
  assign dy = 25'(point_y) - 25'(centre_y);
  assign dz = 25'(point_z) - 25'(centre_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      vld[0] <= 1'b0;
    end else begin
      v1     <= in_valid;
      v2     <= v1;
      vld[0] <= v2;
    end
    mx      <= dx[24] ? 25'(-dx) : 25'(dx);
    my      <= dy[24] ? 25'(-dy) : 25'(dy);
    mz      <= dz[24] ? 25'(-dz) : 25'(dz);
    sqx     <= 49'(50'(mx) * 50'(mx));
    sqy     <= 49'(50'(my) * 50'(my));
    sqz     <= 49'(50'(mz) * 50'(mz));
    rem[0]  <= 50'(sqx) + 50'(sqy) + 50'(sqz);
    root[0] <= '0;
  end

  // one root bit per stage, trial bit walks down two places each time
  for (genvar i = 0; i < 25; i++) begin : g_sqrt
    localparam logic [49:0] BIT = 50'(1) << (48 - 2 * i);
    logic [49:0] trial;
    assign trial = root[i] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (rem[i] >= trial) begin
        rem[i+1]  <= rem[i] - trial;
        root[i+1] <= (root[i] >> 1) + BIT;
      end else begin
        rem[i+1]  <= rem[i];
        root[i+1] <= root[i] >> 1;
      end
    end
  end

  assign dout.valid    = vld[25];
  assign dout.distance = root[25][24:0];

endmodule

>>> design/dsp_arg.sv
// argument stages: offset numerator, saturation test and pipelined division by the width
module dsp_arg import dsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dist_beat_t  din,
  input  logic [23:0] radius,
  input  logic [23:0] width,
  output arg_beat_t   dout
);

  logic               v1;
  logic signed [26:0] num;
  logic [25:0]        nmag;
  logic [23:0]        wdiv;

  logic        vld [0:19];
  logic        sat [0:19];
  logic        neg [0:19];
  logic [41:0] rem [0:19];
  logic [18:0] quo [0:19];

  assign nmag = num[26] ? 26'(-num) : 26'(num);
  assign wdiv = (width == '0) ? 24'd1 : width;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      vld[0] <= 1'b0;
    end else begin
      v1     <= din.valid;
      vld[0] <= v1;
    end
    num    <= signed'({1'b0, din.distance, 1'b0}) - signed'({3'b0, radius});
    neg[0] <= num[26];
    sat[0] <= {1'b0, nmag} >= {wdiv, 3'b000};
    rem[0] <= {nmag, 16'b0};
    quo[0] <= '0;
  end

  // restoring division, quotient bit 18 down to 0
  for (genvar i = 0; i < 19; i++) begin : g_div
    localparam int B = 18 - i;
    logic [41:0] trial;
    assign trial = 42'(wdiv) << B;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      sat[i+1] <= sat[i];
      neg[i+1] <= neg[i];
      if (rem[i] >= trial) begin
        rem[i+1] <= rem[i] - trial;
        quo[i+1] <= quo[i] | (19'(1) << B);
      end else begin
        rem[i+1] <= rem[i];
        quo[i+1] <= quo[i];
      end
    end
  end

  assign dout.valid = vld[19];
  assign dout.sat   = sat[19];
  assign dout.neg   = neg[19];
  assign dout.amag  = quo[19];

endmodule

>>> design/dsp_tanh.sv
// tanh stages: exp series, power table, quotient divider and blend weight
module dsp_tanh import dsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  arg_beat_t    din,
  output weight_beat_t dout
);

  typedef struct packed {
    logic        sat;
    logic        neg;
    logic [3:0]  n;
    logic [15:0] x;
    logic [32:0] term;
    logic [32:0] v;
    logic [67:0] pm;
    logic [34:0] pos;
    logic [34:0] ng;
  } ser_t;

  ser_t entry;
  ser_t sa [1:16];
  ser_t sb [1:16];
  ser_t sc [1:16];
  logic va [1:16];
  logic vb [1:16];
  logic vc [1:16];

  // y = 2a split into integer part n and fraction x
  assign entry.sat  = din.sat;
  assign entry.neg  = din.neg;
  assign entry.n    = din.amag[18:15];
  assign entry.x    = {din.amag[14:0], 1'b0};
  assign entry.term = ONE_Q32;
  assign entry.v    = '0;
  assign entry.pm   = '0;
  assign entry.pos  = 35'(ONE_Q32);
  assign entry.ng   = '0;

  // three stages per series term: product, reciprocal multiply, correction
  for (genvar k = 1; k <= 16; k++) begin : g_term
    localparam logic [34:0] RECIP = 35'((68'd1 << 34) / k);
    ser_t        pin;
    logic        pv;
    logic [32:0] q0, rem, qk;
    ser_t        a_next, b_next, c_next;
    if (k == 1) begin : g_first
      assign pin = entry;
      assign pv  = din.valid;
    end else begin : g_next
      assign pin = sc[k-1];
      assign pv  = vc[k-1];
    end
    assign q0  = 33'(sb[k].pm >> 34);
    assign rem = sb[k].v - 33'(q0 * 33'(k));
    assign qk  = (rem >= 33'(k)) ? q0 + 33'd1 : q0;

    always_comb begin
      a_next   = pin;
      a_next.v = 33'((66'(pin.term) * 66'(pin.x)) >> 16);
    end

    always_comb begin
      b_next    = sa[k];
      b_next.pm = 68'(sa[k].v) * 68'(RECIP);
    end

    always_comb begin
      c_next      = sb[k];
      c_next.term = qk;
      if ((k % 2) == 1) begin
        c_next.ng = sb[k].ng + 35'(qk);
      end else begin
        c_next.pos = sb[k].pos + 35'(qk);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        va[k] <= 1'b0;
        vb[k] <= 1'b0;
        vc[k] <= 1'b0;
      end else begin
        va[k] <= pv;
        vb[k] <= va[k];
        vc[k] <= vb[k];
      end
      sa[k] <= a_next;
      sb[k] <= b_next;
      sc[k] <= c_next;
    end
  end

  logic        vp, vm;
  logic        sat_p, neg_p, nz_p, sat_m, neg_m;
  logic [32:0] ef, pw, e;
  logic [63:0] eprod;
  logic [32:0] escaled;

  assign eprod   = 64'(pw[30:0]) * 64'(ef);
  assign escaled = nz_p ? 33'(eprod >> 32) : ef;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      vm <= 1'b0;
    end else begin
      vp <= vc[16];
      vm <= vp;
    end
    ef    <= (sc[16].ng > sc[16].pos) ? '0 : 33'(sc[16].pos - sc[16].ng);
    pw    <= E1_POW[sc[16].n];
    nz_p  <= (sc[16].n != '0);
    sat_p <= sc[16].sat;
    neg_p <= sc[16].neg;
    e     <= (escaled > ONE_Q32) ? ONE_Q32 : escaled;
    sat_m <= sat_p;
    neg_m <= neg_p;
  end

  logic        dv  [0:29];
  logic        dsat [0:29];
  logic        dneg [0:29];
  logic [60:0] dr  [0:29];
  logic [33:0] dd  [0:29];
  logic [28:0] dq  [0:29];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= vm;
    end
    dr[0]   <= {33'(ONE_Q32 - e), 28'b0};
    dd[0]   <= 34'(ONE_Q32) + 34'(e);
    dq[0]   <= '0;
    dsat[0] <= sat_m;
    dneg[0] <= neg_m;
  end

  // restoring division (1 - e) / (1 + e), quotient bit 28 down to 0
  for (genvar i = 0; i < 29; i++) begin : g_div
    localparam int B = 28 - i;
    logic [62:0] trial;
    assign trial = 63'(dd[i]) << B;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else begin
        dv[i+1] <= dv[i];
      end
      dd[i+1]   <= dd[i];
      dsat[i+1] <= dsat[i];
      dneg[i+1] <= dneg[i];
      if (63'(dr[i]) >= trial) begin
        dr[i+1] <= 61'(63'(dr[i]) - trial);
        dq[i+1] <= dq[i] | (29'(1) << B);
      end else begin
        dr[i+1] <= dr[i];
        dq[i+1] <= dq[i];
      end
    end
  end

  logic [28:0] tval;
  logic        wv;
  logic [29:0] weight;

  assign tval = dsat[29] ? ONE_Q28 : dq[29];

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
    end else begin
      wv <= dv[29];
    end
    weight <= dneg[29] ? 30'(ONE_Q28) - 30'(tval) : 30'(ONE_Q28) + 30'(tval);
  end

  assign dout.valid  = wv;
  assign dout.weight = weight;

endmodule

>>> design/dsp_checker.sv
// port-level checks for the diffuse sphere profile top level and their binding
module dsp_checker import dsp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  // reset leaves nothing in flight
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

  // every result comes from a start beat a fixed latency earlier
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, DSP_LATENCY))
    else $error("result strobe without a matching start beat");

  // the pipeline never refuses a point
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("start refused");

  // register writes are never held off
  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration beat held off");

endmodule

bind diffuse_sphere_profile_top dsp_checker u_checker (.*);
